FILE: hw/rtl/chip8_instruction_execute_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CHIP-8 execute unit
// Shared property forms, all disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication
`define C8_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define C8_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/c8ieu_pkg.sv
// ----------------------------------------------------------------------------
// c8ieu_pkg
// Types, codes and helpers for the CHIP-8 instruction execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package c8ieu_pkg;

   localparam int MEM_BYTES      = 4096;
   localparam int STACK_DEPTH    = 16;
   localparam int DISPLAY_WIDTH  = 64;
   localparam int DISPLAY_HEIGHT = 32;

   localparam int MEM_AW   = $clog2(MEM_BYTES);
   localparam int STK_AW   = $clog2(STACK_DEPTH);
   localparam int STK_CW   = $clog2(STACK_DEPTH + 1);
   localparam int ROW_AW   = $clog2(DISPLAY_HEIGHT);
   localparam int COL_AW   = $clog2(DISPLAY_WIDTH);

   localparam logic [11:0] FONT_RESET = 12'h200;
   localparam logic [15:0] SEED_RESET = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS  = 16'hB400;

   // request kinds
   localparam logic [2:0] REQ_EXEC = 3'd0;
   localparam logic [2:0] REQ_MEMW = 3'd1;
   localparam logic [2:0] REQ_MEMR = 3'd2;
   localparam logic [2:0] REQ_ROW  = 3'd3;
   localparam logic [2:0] REQ_REG  = 3'd4;

   // config register indexes
   localparam logic CSR_FONT_BASE = 1'b0;
   localparam logic CSR_SEED      = 1'b1;

   // opcode groups (top nibble)
   localparam logic [3:0] OP_SYS  = 4'h0;
   localparam logic [3:0] OP_JP   = 4'h1;
   localparam logic [3:0] OP_CALL = 4'h2;
   localparam logic [3:0] OP_SEK  = 4'h3;
   localparam logic [3:0] OP_SNEK = 4'h4;
   localparam logic [3:0] OP_SER  = 4'h5;
   localparam logic [3:0] OP_LDK  = 4'h6;
   localparam logic [3:0] OP_ADDK = 4'h7;
   localparam logic [3:0] OP_ALU  = 4'h8;
   localparam logic [3:0] OP_SNER = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_JPV  = 4'hB;
   localparam logic [3:0] OP_RND  = 4'hC;
   localparam logic [3:0] OP_DRW  = 4'hD;
   localparam logic [3:0] OP_MISC = 4'hF;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   // ALU sub-ops
   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_SBN = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   // FX sub-ops
   localparam logic [7:0] FX_ADDI = 8'h1E;
   localparam logic [7:0] FX_FONT = 8'h29;
   localparam logic [7:0] FX_BCD  = 8'h33;
   localparam logic [7:0] FX_STOR = 8'h55;
   localparam logic [7:0] FX_LOAD = 8'h65;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_SKIP  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RDX, ST_RDY, ST_EXEC, ST_POP, ST_WRF, ST_RDM, ST_RDD,
      ST_BCD, ST_STR, ST_STW, ST_LDR, ST_LDW, ST_DRR, ST_DRW, ST_DONE
   } state_type;

   // BCD digits {ones, tens, hundreds}, lowest digit field is hundreds
   function automatic logic [11:0] bcd_digits(input logic [7:0] val);
      logic [1:0]  hun;
      logic [6:0]  rem;
      logic [14:0] prod;
      logic [3:0]  ten;
      logic [3:0]  one;
      hun  = (val >= 8'd200) ? 2'd2 : ((val >= 8'd100) ? 2'd1 : 2'd0);
      rem  = 7'(val - 8'(hun) * 8'd100);
      prod = 15'(rem) * 15'd205;       // rem / 10 for rem < 100
      ten  = prod[14:11];
      one  = 4'(rem - 7'(ten) * 7'd10);
      return {one, ten, 2'b00, hun};
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/c8ieu_ram.sv
// ----------------------------------------------------------------------------
// c8ieu_ram
// Single-port synchronous RAM, read-first, with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module c8ieu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[addr];
      if (we) begin
         mem_ff[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/chip8_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// chip8_instruction_execute_unit
// Executes CHIP-8 opcodes and host memory/display/register requests.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one request item; req_tuser is the request kind
//   (execute, memory write, memory read, display row read, register read).
//   rsp_ channel returns exactly one item per request: status on rsp_tuser,
//   read data, program counter and index register on rsp_tdata.
//   csr_ writes font_base (index 0) or reloads the LFSR seed (index 1);
//   write only while no request is in flight.
// Sequencing:
//   One item at a time. A simple request passes the VX read, VY read,
//   execute and result states before rsp_tvalid rises; the next item is
//   taken only after the result state. Memory and display row reads add a
//   read state, ALU ops with a flag a VF write, returns a stack pop, BCD a
//   write per digit, FX55/FX65 a read and a write per register, draw a row
//   read and write per drawn row, a row read for a row cut off at the bottom
//   and a VF write; registers, memory, stack and display are single-port RAMs.
// Reset:
//   Registers, index, PC, stack count and display read as zero, the LFSR
//   holds the seed. Memory and return stack hold garbage until written.
// Stall:
//   The result sits in an output register; the unit leaves its result state
//   once that register is empty or being read, then takes a new request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chip8_instruction_execute_unit_macros.svh"

module chip8_instruction_execute_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: req_tdata = opcode, mem_addr, mem_data, row_select, reg_select
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic [2:0]  req_tuser,   // req_type
   // response: rsp_tdata = read_data, prog_counter, index_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,   // status
   // config writes
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   import c8ieu_pkg::*;

   // ---------------- registers ----------------
   state_type                  state_ff, state_in;
   logic [2:0]                 req_ff, req_in;
   logic [15:0]                op_ff, op_in;
   logic [MEM_AW-1:0]          maddr_ff, maddr_in;
   logic [7:0]                 mdata_ff, mdata_in;
   logic [ROW_AW-1:0]          row_ff, row_in;
   logic [3:0]                 regsel_ff, regsel_in;

   logic [11:0]                pc_ff, pc_in;
   logic [15:0]                idx_ff, idx_in;
   logic [STK_CW-1:0]          cnt_ff, cnt_in;
   logic [15:0]                lfsr_ff, lfsr_in;
   logic [11:0]                font_ff, font_in;
   logic [15:0]                vval_ff, vval_in;
   logic [DISPLAY_HEIGHT-1:0]  dval_ff, dval_in;
   logic [3:0]                 vaddr_ff;
   logic [ROW_AW-1:0]          daddr_ff;

   logic [7:0]                 vx_ff, vx_in;
   logic [3:0]                 step_ff, step_in;
   logic                       flag_ff, flag_in;
   logic [11:0]                bcd_ff, bcd_in;
   status_type                 stat_ff, stat_in;
   logic [63:0]                rd_ff, rd_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 rsp_stat_ff;
   logic [63:0]                rsp_rd_ff;
   logic [11:0]                rsp_pc_ff;
   logic [15:0]                rsp_idx_ff;

   // ---------------- RAM ports ----------------
   logic                       v_we, m_we, s_we, d_we;
   logic [3:0]                 v_addr;
   logic [MEM_AW-1:0]          m_addr;
   logic [STK_AW-1:0]          s_addr;
   logic [ROW_AW-1:0]          d_addr;
   logic [7:0]                 v_wdata, v_rdata, m_wdata, m_rdata;
   logic [11:0]                s_wdata, s_rdata;
   logic [DISPLAY_WIDTH-1:0]   d_wdata, d_rdata;

   c8ieu_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
      .clock(clock), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata));
   c8ieu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock(clock), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));
   c8ieu_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
   c8ieu_ram #(.WIDTH(DISPLAY_WIDTH), .DEPTH(DISPLAY_HEIGHT)) u_disp (
      .clock(clock), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata));

   // ---------------- decode ----------------
   logic        req_acc, rsp_free;
   logic [3:0]  grp, op_x, op_y, op_n;
   logic [7:0]  op_nn;
   logic [11:0] op_nnn;
   logic [7:0]  v_rd;
   logic [63:0] d_rd;
   logic [15:0] lfsr_nxt;
   logic [MEM_AW-1:0] i_addr;
   logic [ROW_AW:0]   py;
   logic [63:0]       spr_mask;
   logic              alu_flagged;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   assign grp    = op_ff[15:12];
   assign op_x   = op_ff[11:8];
   assign op_y   = op_ff[7:4];
   assign op_n   = op_ff[3:0];
   assign op_nn  = op_ff[7:0];
   assign op_nnn = op_ff[11:0];

   // unwritten registers and rows read as zero
   assign v_rd = vval_ff[vaddr_ff] ? v_rdata : 8'h00;
   assign d_rd = dval_ff[daddr_ff] ? d_rdata : 64'h0;

   assign lfsr_nxt = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 16'h0000);
   assign i_addr   = idx_ff[MEM_AW-1:0] + MEM_AW'(step_ff);
   // draw row: VY held in rd_ff during the row walk
   assign py       = {1'b0, rd_ff[ROW_AW-1:0]} + (ROW_AW+1)'(step_ff);
   assign spr_mask = {m_rdata, 56'h0} >> vx_ff[COL_AW-1:0];

   always_comb begin
      case (op_n) inside
         ALU_ADD, ALU_SUB, ALU_SBN, ALU_SHR, ALU_SHL: alu_flagged = 1'b1;
         default:                                    alu_flagged = 1'b0;
      endcase
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_IDLE: if (req_acc) state_in = ST_RDX;
         ST_RDX:  state_in = ST_RDY;
         ST_RDY:  state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = ST_DONE;
            if (req_ff == REQ_MEMR) begin
               state_in = ST_RDM;
            end else if (req_ff == REQ_ROW) begin
               state_in = ST_RDD;
            end else if (req_ff == REQ_EXEC) begin
               unique case (grp)
                  OP_SYS:  if (op_ff == OP_RET && cnt_ff != '0) state_in = ST_POP;
                  OP_ALU:  if (alu_flagged) state_in = ST_WRF;
                  OP_DRW:  state_in = (op_n == 4'h0) ? ST_WRF : ST_DRR;
                  OP_MISC: begin
                     if (op_nn == FX_BCD)       state_in = ST_BCD;
                     else if (op_nn == FX_STOR) state_in = ST_STR;
                     else if (op_nn == FX_LOAD) state_in = ST_LDR;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_POP, ST_WRF, ST_RDM, ST_RDD: state_in = ST_DONE;
         ST_BCD:  if (step_ff == 4'd2) state_in = ST_DONE;
         ST_STR:  state_in = ST_STW;
         ST_STW:  state_in = (step_ff == op_x) ? ST_DONE : ST_STR;
         ST_LDR:  state_in = ST_LDW;
         ST_LDW:  state_in = (step_ff == op_x) ? ST_DONE : ST_LDR;
         ST_DRR:  state_in = py[ROW_AW] ? ST_WRF : ST_DRW;
         ST_DRW:  state_in = (step_ff == op_n - 4'd1) ? ST_WRF : ST_DRR;
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath and RAM control ----------------
   always_comb begin
      req_in    = req_ff;    op_in    = op_ff;    maddr_in  = maddr_ff;
      mdata_in  = mdata_ff;  row_in   = row_ff;   regsel_in = regsel_ff;
      pc_in     = pc_ff;     idx_in   = idx_ff;   cnt_in    = cnt_ff;
      lfsr_in   = lfsr_ff;   font_in  = font_ff;  vval_in   = vval_ff;
      dval_in   = dval_ff;   vx_in    = vx_ff;    step_in   = step_ff;
      flag_in   = flag_ff;   bcd_in   = bcd_ff;   stat_in   = stat_ff;
      rd_in     = rd_ff;
      v_we = 1'b0; v_addr = 4'h0;     v_wdata = 8'h00;
      m_we = 1'b0; m_addr = i_addr;   m_wdata = 8'h00;
      s_we = 1'b0; s_addr = '0;       s_wdata = pc_ff;
      d_we = 1'b0; d_addr = '0;       d_wdata = d_rd ^ spr_mask;

      // config writes
      if (csr_we) begin
         if (csr_index == CSR_FONT_BASE) font_in = csr_wdata[11:0];
         else                            lfsr_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               req_in    = req_tuser;
               op_in     = req_tdata[15:0];
               maddr_in  = req_tdata[27:16];
               mdata_in  = req_tdata[35:28];
               row_in    = req_tdata[40:36];
               regsel_in = req_tdata[44:41];
            end
         end
         ST_RDX: v_addr = (req_ff == REQ_REG) ? regsel_ff : op_x;
         ST_RDY: begin
            v_addr = (grp == OP_JPV) ? 4'h0 : op_y;
            vx_in  = v_rd;
         end
         ST_EXEC: begin
            stat_in = STAT_DONE;
            rd_in   = 64'h0;
            step_in = 4'h0;
            flag_in = 1'b0;
            v_addr  = op_x;
            case (req_ff)
               REQ_MEMW: begin
                  m_we = 1'b1; m_addr = maddr_ff; m_wdata = mdata_ff;
               end
               REQ_MEMR: m_addr = maddr_ff;
               REQ_ROW:  d_addr = row_ff;
               REQ_REG:  rd_in = 64'(vx_ff);
               REQ_EXEC: begin
                  unique case (grp) inside
                     OP_SYS: begin
                        if (op_ff == OP_CLS) begin
                           dval_in = '0;
                        end else if (op_ff == OP_RET) begin
                           if (cnt_ff == '0) begin
                              stat_in = STAT_EMPTY;
                           end else begin
                              cnt_in = cnt_ff - 1'b1;
                              s_addr = STK_AW'(cnt_ff - 1'b1);
                           end
                        end
                     end
                     OP_JP: pc_in = op_nnn;
                     OP_CALL: begin
                        if (cnt_ff >= STK_CW'(STACK_DEPTH)) begin
                           stat_in = STAT_FULL;
                        end else begin
                           s_we   = 1'b1;
                           s_addr = STK_AW'(cnt_ff);
                           cnt_in = cnt_ff + 1'b1;
                           pc_in  = op_nnn;
                        end
                     end
                     OP_SEK, OP_SNEK, OP_SER, OP_SNER: begin
                        if ((grp == OP_SER || grp == OP_SNER) && op_n != 4'h0) begin
                           stat_in = STAT_DONE;
                        end else if ((grp == OP_SEK  && vx_ff == op_nn) ||
                                     (grp == OP_SNEK && vx_ff != op_nn) ||
                                     (grp == OP_SER  && vx_ff == v_rd)  ||
                                     (grp == OP_SNER && vx_ff != v_rd)) begin
                           pc_in = pc_ff + 12'd2;
                        end else begin
                           stat_in = STAT_SKIP;
                        end
                     end
                     OP_LDK: begin
                        v_we = 1'b1; v_wdata = op_nn;
                     end
                     OP_ADDK: begin
                        v_we = 1'b1; v_wdata = vx_ff + op_nn;
                     end
                     OP_ALU: begin
                        v_we = 1'b1;
                        case (op_n)
                           ALU_MOV: v_wdata = v_rd;
                           ALU_OR:  v_wdata = vx_ff | v_rd;
                           ALU_AND: v_wdata = vx_ff & v_rd;
                           ALU_XOR: v_wdata = vx_ff ^ v_rd;
                           ALU_ADD: begin
                              {flag_in, v_wdata} = {1'b0, vx_ff} + {1'b0, v_rd};
                           end
                           ALU_SUB: begin
                              v_wdata = vx_ff - v_rd; flag_in = (vx_ff >= v_rd);
                           end
                           ALU_SBN: begin
                              v_wdata = v_rd - vx_ff; flag_in = (vx_ff <= v_rd);
                           end
                           ALU_SHR: begin
                              v_wdata = {1'b0, vx_ff[7:1]}; flag_in = vx_ff[0];
                           end
                           ALU_SHL: begin
                              v_wdata = {vx_ff[6:0], 1'b0}; flag_in = vx_ff[7];
                           end
                           default: v_we = 1'b0;
                        endcase
                     end
                     OP_LDI: idx_in = {4'h0, op_nnn};
                     OP_JPV: pc_in = op_nnn + 12'(v_rd);
                     OP_RND: begin
                        lfsr_in = lfsr_nxt;
                        v_we = 1'b1; v_wdata = lfsr_nxt[7:0] & op_nn;
                     end
                     OP_DRW: begin
                        // keep VY in rd_ff low bits for the row walk
                        rd_in = 64'(v_rd);
                     end
                     OP_MISC: begin
                        if (op_nn == FX_ADDI) idx_in = idx_ff + 16'(vx_ff);
                        else if (op_nn == FX_FONT)
                           idx_in = 16'(font_ff) + 16'({vx_ff, 2'b00}) + 16'(vx_ff);
                        else if (op_nn == FX_BCD) bcd_in = bcd_digits(vx_ff);
                     end
                     default: stat_in = STAT_DONE;
                  endcase
               end
               default: stat_in = STAT_DONE;
            endcase
            if (v_we) vval_in[v_addr] = 1'b1;
         end
         ST_POP: pc_in = s_rdata;
         ST_WRF: begin
            v_we = 1'b1; v_addr = 4'hF; v_wdata = {7'h00, flag_ff};
            vval_in[4'hF] = 1'b1;
            if (grp == OP_DRW) rd_in = 64'h0;
         end
         ST_RDM: rd_in = 64'(m_rdata);
         ST_RDD: rd_in = d_rd;
         ST_BCD: begin
            m_we    = 1'b1;
            m_wdata = (step_ff == 4'd0) ? {6'h00, bcd_ff[1:0]} :
                      (step_ff == 4'd1) ? {4'h0, bcd_ff[7:4]} : {4'h0, bcd_ff[11:8]};
            step_in = step_ff + 4'd1;
         end
         ST_STR: v_addr = step_ff;
         ST_STW: begin
            m_we = 1'b1; m_wdata = v_rd;
            step_in = step_ff + 4'd1;
         end
         ST_LDR: m_addr = i_addr;
         ST_LDW: begin
            v_we = 1'b1; v_addr = step_ff; v_wdata = m_rdata;
            vval_in[step_ff] = 1'b1;
            step_in = step_ff + 4'd1;
         end
         ST_DRR: begin
            // sprite byte and target row fetched together
            m_addr = i_addr;
            d_addr = py[ROW_AW-1:0];
         end
         ST_DRW: begin
            d_we    = 1'b1;
            d_addr  = daddr_ff;
            dval_in[daddr_ff] = 1'b1;
            flag_in = flag_ff | (|(d_rd & spr_mask));
            step_in = step_ff + 4'd1;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // ---------------- response register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (state_ff == ST_DONE && rsp_free) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         lfsr_ff      <= SEED_RESET;
         font_ff      <= FONT_RESET;
         vval_ff      <= '0;
         dval_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         lfsr_ff      <= lfsr_in;
         font_ff      <= font_in;
         vval_ff      <= vval_in;
         dval_ff      <= dval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      op_ff     <= op_in;
      maddr_ff  <= maddr_in;
      mdata_ff  <= mdata_in;
      row_ff    <= row_in;
      regsel_ff <= regsel_in;
      vx_ff     <= vx_in;
      step_ff   <= step_in;
      flag_ff   <= flag_in;
      bcd_ff    <= bcd_in;
      stat_ff   <= stat_in;
      rd_ff     <= rd_in;
      vaddr_ff  <= v_addr;
      daddr_ff  <= d_addr;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_stat_ff <= stat_ff;
         rsp_rd_ff   <= rd_ff;
         rsp_pc_ff   <= pc_ff;
         rsp_idx_ff  <= idx_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = {4'h0, rsp_idx_ff, rsp_pc_ff, rsp_rd_ff};

   // ---------------- checks ----------------
   `C8_ASSERT_NXT(a_busy_after_accept, clock, reset, req_acc, state_ff == ST_RDX,
      "accepted item did not start operand read")
   `C8_ASSERT_IMP(a_disp_write_in_draw, clock, reset, d_we, state_ff == ST_DRW,
      "display written outside draw")
   `C8_ASSERT_IMP(a_stack_bound, clock, reset, s_we, cnt_ff < STK_CW'(STACK_DEPTH),
      "push on full stack")
   `C8_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_DONE, "response raised outside result state")
   `C8_ASSERT_IMP(a_row_walk, clock, reset, state_ff == ST_DRW, !py[ROW_AW],
      "draw row past bottom edge")

endmodule

`default_nettype wire

FILE: tb/tb_chip8_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// tb_chip8_instruction_execute_unit
// Self-checking bench for the CHIP-8 execute unit. A scoreboard class mirrors
// registers, index, PC, stack, memory, display and LFSR, predicts one result
// per accepted request and checks each returned item in order. Memory is
// filled first so that no read ever touches an unwritten byte. Then come
// directed opcodes, and after that random phases under several font base and
// seed settings, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_chip8_instruction_execute_unit;
   import c8ieu_pkg::*;

   localparam int LIMIT      = 1500000;
   localparam int PHASE_REQS = 150;

   typedef struct {
      logic [2:0]  kind;
      logic [15:0] opcode;
      logic [11:0] addr;
      logic [7:0]  wdata;
      logic [4:0]  row;
      logic [3:0]  rsel;
   } request_type;

   typedef struct {
      status_type  status;
      logic [63:0] rdata;
      logic [11:0] pc;
      logic [15:0] index;
   } outcome_type;

   // Mirror of the unit's state; predicts and checks outcomes in order
   class exec_scoreboard;
      logic [7:0]  v [16];
      logic [15:0] ireg;
      logic [11:0] pc;
      logic [11:0] stk [STACK_DEPTH];
      int          depth;
      logic [7:0]  mem [MEM_BYTES];
      logic [63:0] disp [DISPLAY_HEIGHT];
      logic [15:0] lfsr;
      logic [11:0] font;
      outcome_type pending [$];
      int          errors;

      function void clear();
         foreach (v[i]) v[i] = '0;
         foreach (disp[i]) disp[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         ireg = '0; pc = '0; depth = 0;
         font = FONT_RESET; lfsr = SEED_RESET;
         errors = 0;
      endfunction

      function void set_csr(logic idx, logic [15:0] val);
         if (idx == CSR_FONT_BASE) font = val[11:0];
         else lfsr = val;
      endfunction

      function void draw_sprite(int x, int y, int n);
         int sx, sy, py, px;
         logic [7:0] bits;
         logic hit;
         sx = v[x] % DISPLAY_WIDTH;
         sy = v[y] % DISPLAY_HEIGHT;
         hit = 0;
         for (int r = 0; r < n; r++) begin
            py = sy + r;
            if (py >= DISPLAY_HEIGHT) break;
            bits = mem[(ireg + r) % MEM_BYTES];
            for (int c = 0; c < 8; c++) begin
               px = sx + c;
               if (px >= DISPLAY_WIDTH) break;
               if (bits[7-c]) begin
                  if (disp[py][63-px]) hit = 1;
                  disp[py][63-px] = ~disp[py][63-px];
               end
            end
         end
         v[15] = {7'b0, hit};
      endfunction

      function status_type run_opcode(logic [15:0] op);
         int x, y;
         logic [3:0] n;
         logic [7:0] nn, vx, vy, res, flag;
         logic [11:0] nnn;
         logic cond;
         x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
         vx = v[x]; vy = v[y];
         case (op[15:12])
            OP_SYS: begin
               if (op == OP_CLS) begin
                  foreach (disp[i]) disp[i] = '0;
               end else if (op == OP_RET) begin
                  if (depth == 0) return STAT_EMPTY;
                  depth--;
                  pc = stk[depth];
               end
               return STAT_DONE;
            end
            OP_JP: begin pc = nnn; return STAT_DONE; end
            OP_CALL: begin
               if (depth >= STACK_DEPTH) return STAT_FULL;
               stk[depth] = pc;
               depth++;
               pc = nnn;
               return STAT_DONE;
            end
            OP_SEK:  cond = (vx == nn);
            OP_SNEK: cond = (vx != nn);
            OP_SER: begin
               if (n != 0) return STAT_DONE;
               cond = (vx == vy);
            end
            OP_SNER: begin
               if (n != 0) return STAT_DONE;
               cond = (vx != vy);
            end
            OP_LDK:  begin v[x] = nn; return STAT_DONE; end
            OP_ADDK: begin v[x] = vx + nn; return STAT_DONE; end
            OP_ALU: begin
               case (n)
                  ALU_MOV: begin v[x] = vy; return STAT_DONE; end
                  ALU_OR:  begin v[x] = vx | vy; return STAT_DONE; end
                  ALU_AND: begin v[x] = vx & vy; return STAT_DONE; end
                  ALU_XOR: begin v[x] = vx ^ vy; return STAT_DONE; end
                  ALU_ADD: begin res = vx + vy; flag = ({1'b0, vx} + vy > 9'hFF); end
                  ALU_SUB: begin res = vx - vy; flag = (vx >= vy); end
                  ALU_SBN: begin res = vy - vx; flag = (vx <= vy); end
                  ALU_SHR: begin res = vx >> 1; flag = {7'b0, vx[0]}; end
                  ALU_SHL: begin res = vx << 1; flag = {7'b0, vx[7]}; end
                  default: return STAT_DONE;
               endcase
               // flag lands after the result, so VF as target keeps the flag
               v[x] = res;
               v[15] = flag;
               return STAT_DONE;
            end
            OP_LDI: begin ireg = {4'b0, nnn}; return STAT_DONE; end
            OP_JPV: begin pc = nnn + {4'b0, v[0]}; return STAT_DONE; end
            OP_RND: begin
               lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
               v[x] = lfsr[7:0] & nn;
               return STAT_DONE;
            end
            OP_DRW: begin draw_sprite(x, y, n); return STAT_DONE; end
            OP_MISC: begin
               case (nn)
                  FX_ADDI: ireg = ireg + vx;
                  FX_FONT: ireg = {4'b0, font} + 16'(5 * vx);
                  FX_BCD: begin
                     mem[ireg % MEM_BYTES]       = vx / 100;
                     mem[(ireg + 1) % MEM_BYTES] = (vx % 100) / 10;
                     mem[(ireg + 2) % MEM_BYTES] = vx % 10;
                  end
                  FX_STOR: for (int i = 0; i <= x; i++) mem[(ireg + i) % MEM_BYTES] = v[i];
                  FX_LOAD: for (int i = 0; i <= x; i++) v[i] = mem[(ireg + i) % MEM_BYTES];
                  default: ;
               endcase
               return STAT_DONE;
            end
            default: return STAT_DONE;
         endcase
         if (!cond) return STAT_SKIP;
         pc = pc + 12'd2;
         return STAT_DONE;
      endfunction

      // accepted request: advance the mirror and queue the outcome
      function void note_request(request_type rq);
         outcome_type o;
         o.status = STAT_DONE;
         o.rdata = '0;
         case (rq.kind)
            REQ_EXEC: o.status = run_opcode(rq.opcode);
            REQ_MEMW: mem[rq.addr] = rq.wdata;
            REQ_MEMR: o.rdata = {56'b0, mem[rq.addr]};
            REQ_ROW:  o.rdata = disp[rq.row];
            REQ_REG:  o.rdata = {56'b0, v[rq.rsel]};
            default: ;
         endcase
         o.pc = pc;
         o.index = ireg;
         pending = {pending, o};
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %h expected %h", what, got, want);
         errors++;
      endtask

      task check_outcome(logic [1:0] st, logic [95:0] d);
         outcome_type e;
         if (pending.size() == 0) begin
            report("unexpected item", d[63:0], '0);
            return;
         end
         e = pending.pop_front();
         if (st != e.status) report("status", 64'(st), 64'(e.status));
         if (d[63:0] != e.rdata) report("read_data", d[63:0], e.rdata);
         if (d[75:64] != e.pc) report("prog_counter", 64'(d[75:64]), 64'(e.pc));
         if (d[91:76] != e.index) report("index_value", 64'(d[91:76]), 64'(e.index));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   exec_scoreboard sb;
   int  idle_pct;     // chance in percent of starting an idle burst
   int  hold_cycles;  // long output hold-off, consumed by the receiver
   int  cycle_cnt;

   chip8_instruction_execute_unit DUT (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // handshake monitor: results are checked before the new request is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_outcome(rsp_tuser, rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_request('{req_tuser, req_tdata[15:0], req_tdata[27:16],
                              req_tdata[35:28], req_tdata[40:36], req_tdata[44:41]});
      end
   end

   // result side: random stalls plus the long hold-off
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_tready = 0;
            stall--;
         end else begin
            rsp_tready = 1;
            if ($urandom_range(99) < idle_pct) stall = $urandom_range(1, 13);
         end
      end
   end

   initial begin
      while (cycle_cnt < LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("[chip8_instruction_execute_unit] ERROR");
      $finish;
   end

   task automatic send(request_type rq);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = rq.kind;
      req_tdata = {3'b0, rq.rsel, rq.row, rq.wdata, rq.addr, rq.opcode};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic request_type noise_req();
      request_type rq;
      rq.kind = REQ_EXEC;
      rq.opcode = 16'($urandom);
      rq.addr = 12'($urandom);
      rq.wdata = 8'($urandom);
      rq.row = 5'($urandom);
      rq.rsel = 4'($urandom);
      return rq;
   endfunction

   task automatic exec(logic [15:0] op);
      request_type rq;
      rq = noise_req();
      rq.opcode = op;
      send(rq);
   endtask

   task automatic ask(logic [2:0] kind);
      request_type rq;
      rq = noise_req();
      rq.kind = kind;
      send(rq);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      sb.set_csr(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   // random opcode, biased toward taken skips and useful operands
   function automatic logic [15:0] pick_opcode();
      logic [3:0] x, y, n;
      logic [7:0] nn;
      logic [3:0] alu_ops [10] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                                   ALU_SUB, ALU_SHR, ALU_SBN, ALU_SHL, 4'h9};
      logic [7:0] fx_ops [11] = '{FX_ADDI, FX_FONT, FX_BCD, FX_STOR, FX_LOAD,
                                  8'h07, 8'h0A, 8'h15, 8'h18, 8'h9E, 8'hA1};
      x = 4'($urandom); y = 4'($urandom); n = 4'($urandom); nn = 8'($urandom);
      case ($urandom_range(0, 19))
         0:  return ($urandom_range(0, 9) == 0) ? OP_CLS : {OP_SYS, 12'($urandom)};
         1:  return OP_RET;
         2:  return {OP_CALL, 12'($urandom)};
         3:  return {OP_JP, 12'($urandom)};
         4:  return {OP_SEK, x, $urandom_range(0, 1) ? sb.v[x] : nn};
         5:  return {OP_SNEK, x, $urandom_range(0, 1) ? sb.v[x] : nn};
         6:  return {OP_SER, x, y, $urandom_range(0, 3) ? 4'h0 : n};
         7:  return {OP_SNER, x, y, $urandom_range(0, 3) ? 4'h0 : n};
         8:  return {OP_LDK, x, nn};
         9:  return {OP_ADDK, x, nn};
         10, 11: return {OP_ALU, x, y, $urandom_range(0, 7) ? alu_ops[$urandom_range(0, 9)] : n};
         12: return {OP_LDI, 12'($urandom)};
         13: return {OP_JPV, 12'($urandom)};
         14: return {OP_RND, x, nn};
         15, 16: return {OP_DRW, x, y, n};
         17, 18: return {OP_MISC, x, $urandom_range(0, 7) ? fx_ops[$urandom_range(0, 10)] : nn};
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(int count);
      request_type rq;
      int sent;
      int k;
      sent = 0;
      while (sent < count) begin
         k = $urandom_range(0, 99);
         if (k < 2) begin
            // nested calls past the stack depth, then unwind past empty
            for (int i = 0; i < STACK_DEPTH + 2; i++) exec({OP_CALL, 12'($urandom)});
            for (int i = 0; i < STACK_DEPTH + 2; i++) exec(OP_RET);
            sent += 2 * STACK_DEPTH + 4;
         end else if (k < 8) begin
            // point the index somewhere and draw from it
            exec({OP_LDI, 12'($urandom)});
            exec({OP_DRW, 4'($urandom), 4'($urandom), 4'($urandom)});
            ask(REQ_ROW);
            sent += 3;
         end else begin
            rq = noise_req();
            k = $urandom_range(0, 99);
            if (k < 70) rq.opcode = pick_opcode();
            else if (k < 78) rq.kind = REQ_MEMW;
            else if (k < 85) rq.kind = REQ_MEMR;
            else if (k < 91) rq.kind = REQ_ROW;
            else if (k < 98) rq.kind = REQ_REG;
            else rq.kind = 3'($urandom_range(5, 7));
            send(rq);
            sent++;
         end
      end
      drain();
   endtask

   initial begin
      sb = new();
      sb.clear();
      idle_pct = 15;
      hold_cycles = 0;
      cycle_cnt = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = REQ_EXEC;
      csr_we = 0;
      csr_index = CSR_FONT_BASE;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // state right after reset
      ask(REQ_REG);
      ask(REQ_ROW);
      exec(OP_RET);

      // fill all of memory with block stores of random register bytes
      for (int r = 0; r < 16; r++) exec({OP_RND, 4'(r), 8'hFF});
      for (int b = 0; b < MEM_BYTES / 16; b++) begin
         exec({OP_RND, 4'(b), 8'hFF});
         exec({OP_LDI, 12'(b * 16)});
         exec({OP_MISC, 4'hF, FX_STOR});
      end

      // directed: ALU flags, VF as target, skips, wraps, BCD, block moves, draw
      exec(16'h60FF); exec(16'h61FF); exec(16'h8014); exec(16'h8F14);
      exec(16'h8106); exec(16'h810E); exec(16'h8015); exec(16'h8017);
      exec(16'h30FE); exec(16'h4000); exec(16'h9010);
      exec(16'hBFFF); exec(16'hAFFE); exec(16'hF01E); exec(16'hF029);
      exec(16'hF033); exec(16'hFF55); exec(16'hFF65);
      exec(16'h623C); exec(16'h631E); exec(16'hD23F); exec(16'hD230);
      exec(16'hC0FF); exec(16'hE09E); exec(OP_CLS);
      ask(3'd7);
      drain();

      // settings sweep; one phase holds the output off for a long stretch
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin write_csr(CSR_FONT_BASE, 16'd0); write_csr(CSR_SEED, 16'd1); end
            1: begin write_csr(CSR_FONT_BASE, 16'hFFF); write_csr(CSR_SEED, 16'hFFFF); end
            2: begin
               write_csr(CSR_FONT_BASE, 16'($urandom_range(0, 4095)));
               write_csr(CSR_SEED, 16'($urandom_range(1, 65535)));
            end
            3: write_csr(CSR_SEED, 16'($urandom_range(1, 65535)));
            4: write_csr(CSR_FONT_BASE, 16'($urandom_range(0, 4095)));
            default: begin
               write_csr(CSR_FONT_BASE, {4'b0, FONT_RESET});
               write_csr(CSR_SEED, SEED_RESET);
            end
         endcase
         idle_pct = (p == 5) ? 0 : ((p == 3) ? 0 : 8 + 12 * (p % 3));
         if (p == 1) hold_cycles = 400;
         random_phase(PHASE_REQS);
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[chip8_instruction_execute_unit] OK");
      end else begin
         $display("[chip8_instruction_execute_unit] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
